### hdl/csg_pkg.sv
package csg_pkg;

   localparam int RANK_W      = 18;
   localparam int CELL_W      = 16;
   localparam int DIM_W       = 7;
   localparam int PER_W       = 3;
   localparam int SLOT_W      = 5;
   localparam int NUM_AXES    = 3;
   localparam int NUM_OFFSETS = 27;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_OFFSETS - 1);

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIMS_X   = 3'd0,
      CSR_DIMS_Y   = 3'd1,
      CSR_DIMS_Z   = 3'd2,
      CSR_PERIODIC = 3'd3,
      CSR_CELLS_X  = 3'd4,
      CSR_CELLS_Y  = 3'd5,
      CSR_CELLS_Z  = 3'd6
   } csg_csr_type;

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_DIV_Z,
      FS_DIV_Y,
      FS_MUL,
      FS_SUM
   } csg_front_state_type;

   typedef struct packed {
      logic [DIM_W-1:0]  dims_x;
      logic [DIM_W-1:0]  dims_y;
      logic [DIM_W-1:0]  dims_z;
      logic [PER_W-1:0]  periodic_mask;
      logic [CELL_W-1:0] cells_x;
      logic [CELL_W-1:0] cells_y;
      logic [CELL_W-1:0] cells_z;
   } csg_cfg_type;

   // one classified query: per-axis cell range, per-axis rank terms for
   // offsets -1, 0, +1 and their presence bits
   typedef struct packed {
      logic [NUM_AXES-1:0][CELL_W-1:0]           lo;
      logic [NUM_AXES-1:0][CELL_W-1:0]           hi;
      logic [NUM_AXES-1:0][2:0][RANK_W-1:0]      term;
      logic [NUM_AXES-1:0][2:0]                  vld;
      logic                                      ok;
   } csg_rec_type;

   typedef struct packed {
      logic        valid;
      csg_rec_type rec;
   } csg_beat_type;

endpackage

### hdl/csg_req_if.sv
interface csg_req_if import csg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RANK_W-1:0] rank;

   modport source (output valid, output rank, input ready);
   modport sink   (input valid, input rank, output ready);
endinterface

### hdl/csg_rsp_if.sv
interface csg_rsp_if import csg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CELL_W-1:0] lo_x;
   logic [CELL_W-1:0] hi_x;
   logic [CELL_W-1:0] lo_y;
   logic [CELL_W-1:0] hi_y;
   logic [CELL_W-1:0] lo_z;
   logic [CELL_W-1:0] hi_z;
   logic [SLOT_W-1:0] neighbor_slot;
   logic [RANK_W-1:0] neighbor_rank;
   logic              has_neighbor;
   logic              rank_ok;
   logic              last;

   modport source (output valid, output lo_x, output hi_x, output lo_y, output hi_y,
                   output lo_z, output hi_z, output neighbor_slot, output neighbor_rank,
                   output has_neighbor, output rank_ok, output last, input ready);
   modport sink   (input valid, input lo_x, input hi_x, input lo_y, input hi_y,
                   input lo_z, input hi_z, input neighbor_slot, input neighbor_rank,
                   input has_neighbor, input rank_ok, input last, output ready);
endinterface

### hdl/csg_div.sv
module csg_div import csg_pkg::*; #(
   parameter int W = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [W-1:0]     dividend,
   input  logic [DIM_W-1:0] divisor,
   output logic             busy,
   output logic [W-1:0]     quotient,
   output logic [DIM_W-1:0] remainder
);

   localparam int STEPS = (W + 1) / 2;
   localparam int WP    = 2 * STEPS;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [WP-1:0]    sh_ff, sh_in;
   logic [DIM_W-1:0] rem_ff, rem_in;
   logic [DIM_W-1:0] div_ff;

   // two restoring steps per cycle
   always_comb begin
      logic [DIM_W:0]   t1, t2;
      logic [DIM_W-1:0] r1;
      logic             q1, q2;
      t1 = {rem_ff, sh_ff[WP-1]};
      q1 = (t1 >= {1'b0, div_ff});
      r1 = q1 ? DIM_W'(t1 - {1'b0, div_ff}) : DIM_W'(t1);
      t2 = {r1, sh_ff[WP-2]};
      q2 = (t2 >= {1'b0, div_ff});
      rem_in = q2 ? DIM_W'(t2 - {1'b0, div_ff}) : DIM_W'(t2);
      sh_in  = {sh_ff[WP-3:0], q1, q2};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(STEPS);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sh_ff  <= WP'(dividend);
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         sh_ff  <= sh_in;
         rem_ff <= rem_in;
      end
   end

   assign busy      = busy_ff;
   assign quotient  = sh_ff[W-1:0];
   assign remainder = rem_ff;

endmodule

### hdl/csg_front.sv
module csg_front import csg_pkg::*; #(
   parameter int MAX_DIMS  = 64,
   parameter int CELL_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   csg_req_if.sink      req_ch,
   input  csg_cfg_type  cfg,
   input  logic         q_full,
   output csg_beat_type push
);

   localparam int CM_W = (CELL_BITS < CELL_W) ? CELL_BITS : CELL_W;
   localparam logic [CELL_W-1:0] CELL_MASK = CELL_W'((33'd1 << CM_W) - 33'd1);
   localparam int DYZ_W  = 2 * DIM_W;
   localparam int DXYZ_W = 3 * DIM_W;
   localparam int PROD_W = DIM_W + CELL_W;

   function automatic logic [DIM_W-1:0] clamp_dims(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] res;
      res = d;
      if (d == '0) begin
         res = DIM_W'(1);
      end else if (32'(d) > 32'(MAX_DIMS)) begin
         res = DIM_W'(MAX_DIMS);
      end
      return res;
   endfunction

   csg_front_state_type state_ff, state_in;

   logic [DIM_W-1:0]  dc [NUM_AXES];
   logic [CELL_W-1:0] cells_m [NUM_AXES];
   logic [DYZ_W-1:0]  dyz_ff;
   logic [DXYZ_W-1:0] dxyz_ff;

   logic              div_start;
   logic [RANK_W-1:0] div_dividend;
   logic [DIM_W-1:0]  div_divisor;
   logic              div_busy;
   logic [RANK_W-1:0] div_quo;
   logic [DIM_W-1:0]  div_rem;

   logic              cell_start;
   logic [NUM_AXES-1:0] cell_busy;
   logic [CELL_W-1:0] cell_w [NUM_AXES];
   logic [DIM_W-1:0]  cell_r [NUM_AXES];

   logic              cap_z, cap_y, do_mul;
   logic [RANK_W-1:0] rank_ff;
   logic [DIM_W-1:0]  c_ff [NUM_AXES];
   logic              ok_ff;
   logic [CELL_W-1:0] p_ff [NUM_AXES];
   logic [RANK_W-1:0] bx_ff, by_ff;
   logic [PROD_W-1:0] p_full [NUM_AXES];
   logic [DXYZ_W-1:0] bx_full;
   logic [DYZ_W-1:0]  by_full;

   assign dc[0]      = clamp_dims(cfg.dims_x);
   assign dc[1]      = clamp_dims(cfg.dims_y);
   assign dc[2]      = clamp_dims(cfg.dims_z);
   assign cells_m[0] = cfg.cells_x & CELL_MASK;
   assign cells_m[1] = cfg.cells_y & CELL_MASK;
   assign cells_m[2] = cfg.cells_z & CELL_MASK;

   // grid strides follow the registers; they settle long before use
   always_ff @(posedge clock) begin
      dyz_ff  <= DYZ_W'(dc[1]) * DYZ_W'(dc[2]);
      dxyz_ff <= DXYZ_W'(dc[0]) * DXYZ_W'(dyz_ff);
   end

   csg_div #(.W(RANK_W)) u_div_rank (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_cell_div
      csg_div #(.W(CELL_W)) u_div_cell (
         .clock     (clock),
         .reset     (reset),
         .start     (cell_start),
         .dividend  (cells_m[i]),
         .divisor   (dc[i]),
         .busy      (cell_busy[i]),
         .quotient  (cell_w[i]),
         .remainder (cell_r[i])
      );
   end

   assign req_ch.ready = (state_ff == FS_IDLE);
   assign cell_start   = req_ch.valid && (state_ff == FS_IDLE);

   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      div_dividend = req_ch.rank;
      div_divisor  = dc[2];
      cap_z        = 1'b0;
      cap_y        = 1'b0;
      do_mul       = 1'b0;
      case (state_ff)
         FS_IDLE: begin
            if (req_ch.valid) begin
               div_start = 1'b1;
               state_in  = FS_DIV_Z;
            end
         end
         FS_DIV_Z: begin
            div_dividend = div_quo;
            div_divisor  = dc[1];
            if (!div_busy) begin
               div_start = 1'b1;
               cap_z     = 1'b1;
               state_in  = FS_DIV_Y;
            end
         end
         FS_DIV_Y: begin
            if (!div_busy && (cell_busy == '0)) begin
               cap_y    = 1'b1;
               state_in = FS_MUL;
            end
         end
         FS_MUL: begin
            do_mul   = 1'b1;
            state_in = FS_SUM;
         end
         FS_SUM: begin
            if (!q_full) begin
               state_in = FS_IDLE;
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_prod
      assign p_full[i] = PROD_W'(c_ff[i]) * PROD_W'(cell_w[i]);
   end
   assign bx_full = DXYZ_W'(c_ff[0]) * DXYZ_W'(dyz_ff);
   assign by_full = DYZ_W'(c_ff[1]) * DYZ_W'(dc[2]);

   always_ff @(posedge clock) begin
      if (cell_start) begin
         rank_ff <= req_ch.rank;
      end
      if (cap_z) begin
         c_ff[2] <= div_rem;
      end
      if (cap_y) begin
         c_ff[1] <= div_rem;
         c_ff[0] <= div_quo[DIM_W-1:0];
         ok_ff   <= (DXYZ_W'(rank_ff) < dxyz_ff);
      end
      if (do_mul) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            p_ff[i] <= p_full[i][CELL_W-1:0];
         end
         bx_ff <= bx_full[RANK_W-1:0];
         by_ff <= RANK_W'(by_full);
      end
   end

   // build the record: cell ranges and the three rank terms per axis
   always_comb begin
      logic [RANK_W-1:0] base   [NUM_AXES];
      logic [RANK_W-1:0] stride [NUM_AXES];
      logic [RANK_W-1:0] total  [NUM_AXES];
      logic              below, at_lo, at_hi, per;
      logic [CELL_W-1:0] lo_v;
      logic [CELL_W:0]   hi_v;
      base[0]   = bx_ff;
      base[1]   = by_ff;
      base[2]   = RANK_W'(c_ff[2]);
      stride[0] = RANK_W'(dyz_ff);
      stride[1] = RANK_W'(dc[2]);
      stride[2] = RANK_W'(1);
      total[0]  = dxyz_ff[RANK_W-1:0];
      total[1]  = RANK_W'(dyz_ff);
      total[2]  = RANK_W'(dc[2]);
      push.valid  = (state_ff == FS_SUM) && !q_full;
      push.rec.ok = ok_ff;
      for (int i = 0; i < NUM_AXES; i++) begin
         below = (DIM_W'(c_ff[i]) < cell_r[i]);
         lo_v  = p_ff[i] + (below ? CELL_W'(c_ff[i]) : CELL_W'(cell_r[i]));
         hi_v  = {1'b0, lo_v} + {1'b0, cell_w[i]} + {{CELL_W{1'b0}}, below};
         at_lo = (c_ff[i] == '0);
         at_hi = ({1'b0, c_ff[i]} + 1'b1) >= {1'b0, dc[i]};
         per   = cfg.periodic_mask[i];
         push.rec.lo[i]      = ok_ff ? lo_v : '0;
         push.rec.hi[i]      = ok_ff ? hi_v[CELL_W-1:0] : '0;
         push.rec.term[i][0] = at_lo ? (total[i] - stride[i]) : (base[i] - stride[i]);
         push.rec.term[i][1] = base[i];
         push.rec.term[i][2] = at_hi ? '0 : (base[i] + stride[i]);
         push.rec.vld[i][0]  = ok_ff && (!at_lo || per);
         push.rec.vld[i][1]  = ok_ff;
         push.rec.vld[i][2]  = ok_ff && (!at_hi || per);
      end
   end

endmodule

### hdl/csg_queue.sv
module csg_queue import csg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  csg_beat_type push,
   output logic         full,
   output csg_beat_type head,
   input  logic         pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   csg_rec_type      mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_pop;

   assign full       = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.rec   = mem_ff[rd_ff];
   assign do_pop     = pop && head.valid;

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ff] <= push.rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push.valid) begin
            wr_ff <= (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (push.valid && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !push.valid) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full || do_pop)
      else $error("queue written while full");

endmodule

### hdl/csg_back.sv
module csg_back import csg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  csg_beat_type head,
   output logic         pop,
   csg_rsp_if.source    rsp_ch
);

   csg_rec_type       rec_ff;
   logic              active_ff;
   logic [1:0]        a_ff, b_ff, c_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              emit, fin, load, out_free;
   logic [RANK_W-1:0] nrank;
   logic              has;

   logic              valid_ff;
   logic [CELL_W-1:0] lo_ff [NUM_AXES];
   logic [CELL_W-1:0] hi_ff [NUM_AXES];
   logic [SLOT_W-1:0] oslot_ff;
   logic [RANK_W-1:0] orank_ff;
   logic              ohas_ff, ook_ff, olast_ff;

   assign out_free = !valid_ff || rsp_ch.ready;
   assign emit     = active_ff && out_free;
   assign fin      = emit && (slot_ff == LAST_SLOT);
   assign load     = head.valid && (!active_ff || fin);
   assign pop      = load;

   assign has   = rec_ff.vld[0][a_ff] && rec_ff.vld[1][b_ff] && rec_ff.vld[2][c_ff];
   assign nrank = rec_ff.term[0][a_ff] + rec_ff.term[1][b_ff] + rec_ff.term[2][c_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         a_ff      <= '0;
         b_ff      <= '0;
         c_ff      <= '0;
         slot_ff   <= '0;
      end else if (load) begin
         active_ff <= 1'b1;
         a_ff      <= '0;
         b_ff      <= '0;
         c_ff      <= '0;
         slot_ff   <= '0;
      end else if (fin) begin
         active_ff <= 1'b0;
      end else if (emit) begin
         slot_ff <= slot_ff + 1'b1;
         if (c_ff == 2'd2) begin
            c_ff <= '0;
            if (b_ff == 2'd2) begin
               b_ff <= '0;
               a_ff <= a_ff + 1'b1;
            end else begin
               b_ff <= b_ff + 1'b1;
            end
         end else begin
            c_ff <= c_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff <= head.rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            lo_ff[i] <= rec_ff.lo[i];
            hi_ff[i] <= rec_ff.hi[i];
         end
         oslot_ff <= slot_ff;
         orank_ff <= has ? nrank : '0;
         ohas_ff  <= has;
         ook_ff   <= rec_ff.ok;
         olast_ff <= (slot_ff == LAST_SLOT);
      end
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.lo_x          = lo_ff[0];
   assign rsp_ch.hi_x          = hi_ff[0];
   assign rsp_ch.lo_y          = lo_ff[1];
   assign rsp_ch.hi_y          = hi_ff[1];
   assign rsp_ch.lo_z          = lo_ff[2];
   assign rsp_ch.hi_z          = hi_ff[2];
   assign rsp_ch.neighbor_slot = oslot_ff;
   assign rsp_ch.neighbor_rank = orank_ff;
   assign rsp_ch.has_neighbor  = ohas_ff;
   assign rsp_ch.rank_ok       = ook_ff;
   assign rsp_ch.last          = olast_ff;

   a_last_beat: assert property (@(posedge clock) disable iff (reset)
      fin |=> rsp_ch.valid && rsp_ch.last)
      else $error("final slot did not produce a last beat");

   a_bad_rank_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.rank_ok |-> !rsp_ch.has_neighbor && (rsp_ch.lo_x == '0)
         && (rsp_ch.hi_z == '0))
      else $error("out-of-range rank produced geometry");

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.has_neighbor |-> rsp_ch.neighbor_rank == '0)
      else $error("absent neighbor carries a rank");

endmodule

### hdl/cartesian_subdomain_geometry_unit.sv
// Cartesian subdomain geometry unit.
//
// Write the grid registers on the csr_ port (dims, periodic mask, cells) while
// the block is idle, then send process ranks on req_ch. Each accepted rank
// produces 27 beats on rsp_ch, one per neighbor offset, dz fastest; every beat
// carries the subdomain cell range, the neighbor slot and rank, and last marks
// the 27th beat.
//
// The front end splits the rank with a shared 2-bit-per-cycle divider (rank /
// dims_z, then quotient / dims_y) while three more dividers work out the cells
// per subdomain; a multiply and a sum step follow. The back end emits the 27
// beats of each rank while the front end works on the next one, so a new rank
// can be accepted before the beats of the last one are all out.
//
// A two-entry record queue separates the parts. When the receiver stalls, the
// output beat holds, the back end stops, and the front end keeps going until
// the queue fills; it then holds its record and req_ch.ready stays low. Reset
// restores the register defaults (one subdomain, one cell per axis, no wrap)
// and empties the queue.
module cartesian_subdomain_geometry_unit import csg_pkg::*; #(
   parameter int MAX_DIMS  = 64,
   parameter int CELL_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   csg_req_if.sink               req_ch,
   csg_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   csg_cfg_type  cfg_ff;
   csg_beat_type push;
   csg_beat_type head;
   logic         q_full;
   logic         pop;

   // configuration registers; unknown indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dims_x        <= DIM_W'(1);
         cfg_ff.dims_y        <= DIM_W'(1);
         cfg_ff.dims_z        <= DIM_W'(1);
         cfg_ff.periodic_mask <= '0;
         cfg_ff.cells_x       <= CELL_W'(1);
         cfg_ff.cells_y       <= CELL_W'(1);
         cfg_ff.cells_z       <= CELL_W'(1);
      end else if (csr_we) begin
         case (csg_csr_type'(csr_index))
            CSR_DIMS_X:   cfg_ff.dims_x        <= csr_wdata[DIM_W-1:0];
            CSR_DIMS_Y:   cfg_ff.dims_y        <= csr_wdata[DIM_W-1:0];
            CSR_DIMS_Z:   cfg_ff.dims_z        <= csr_wdata[DIM_W-1:0];
            CSR_PERIODIC: cfg_ff.periodic_mask <= csr_wdata[PER_W-1:0];
            CSR_CELLS_X:  cfg_ff.cells_x       <= csr_wdata[CELL_W-1:0];
            CSR_CELLS_Y:  cfg_ff.cells_y       <= csr_wdata[CELL_W-1:0];
            CSR_CELLS_Z:  cfg_ff.cells_z       <= csr_wdata[CELL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // front: accept a rank, divide it into coordinates, build the record
   csg_front #(
      .MAX_DIMS  (MAX_DIMS),
      .CELL_BITS (CELL_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .cfg    (cfg_ff),
      .q_full (q_full),
      .push   (push)
   );

   // hold finished records until the back end takes them
   csg_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .head  (head),
      .pop   (pop)
   );

   // back: walk the 27 offsets and drive one beat per cycle unless the receiver stalls
   csg_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
